/* design/cft_pkg.sv */
// Shared types and constants for the chemical formula tokenizer.
// Used by cft_parse, cft_fifo, the top level and the checker.
package cft_pkg;

  localparam int unsigned SymbolChars = 3;
  localparam int unsigned SymbolBits  = 8 * SymbolChars;
  localparam int unsigned FillBits    = $clog2(SymbolChars + 1);
  localparam int unsigned CountBits   = 16;
  localparam int unsigned ProdBits    = CountBits + 4;
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};
  localparam logic [CountBits-1:0] CountOne = CountBits'(1);

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrBits   = $clog2(FifoDepth);
  localparam int unsigned LvlBits   = $clog2(FifoDepth + 1);

  localparam int unsigned TdataBits = 48;

  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5A;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerZ = 8'h7A;

  typedef struct packed {
    logic [SymbolBits-1:0] symbol_text;
    logic [FillBits-1:0]   symbol_length;
    logic                  symbol_truncated;
    logic [CountBits-1:0]  atom_count;
    logic                  count_saturated;
    logic                  formula_end;
  } record_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
    logic       valid;
  } step_t;

  typedef struct packed {
    record_t    rec0;
    record_t    rec1;
    logic [1:0] num;
  } result_t;

endpackage

/* design/chemical_formula_tokenizer_core.sv */
// Top level of the chemical formula tokenizer: input register, parse step,
// result queue. Depends on cft_pkg, cft_parse and cft_fifo.
//
// Usage: characters arrive on the s_axis channel, one per word, with tdata
// holding the ASCII code and tlast marking the final character of a
// formula. Records leave on the m_axis channel, one per word: an element
// symbol with its atom count and status flags; tlast marks the final
// record of a formula.
// Path: an accepted character is held in the input register, parsed from
// there into the result queue, and its records are offered from its head.
// Throughput: one character per cycle. A character that yields two
// records needs two output words; the four-entry result queue absorbs
// this, and s_axis_tready falls while fewer than two entries are free.
// Reset: clears the parse state and empties the queue; the next character
// starts a new formula.
// Stall: when m_axis_tready is low the head record holds, the queue
// fills, and input is then held off; nothing is dropped.
module chemical_formula_tokenizer_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // char_code
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // symbol_text[23:0], symbol_length[25:24], symbol_truncated[26],
  // atom_count[42:27], count_saturated[43], zero[47:44]
  output logic [cft_pkg::TdataBits-1:0]  m_axis_tdata,
  output logic                           m_axis_tlast
);

  logic                          in_valid_q;
  logic [7:0]                    in_char_q;
  logic                          in_last_q;
  logic                          consume;
  logic                          pop;
  logic [cft_pkg::LvlBits-1:0]   level;
  cft_pkg::step_t                step;
  cft_pkg::result_t              res;
  cft_pkg::record_t              head;

  assign consume       = in_valid_q
                       && (level <= cft_pkg::LvlBits'(cft_pkg::FifoDepth - 2));
  assign s_axis_tready = !in_valid_q || consume;
  assign step          = '{in_char_q, in_last_q, consume};
  assign pop           = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  cft_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .res_o  (res)
  );

  cft_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_i      (res),
    .pop_i      (pop),
    .head_o     (head),
    .nonempty_o (m_axis_tvalid),
    .level_o    (level)
  );

  assign m_axis_tdata = {4'b0000, head.count_saturated, head.atom_count,
                         head.symbol_truncated, head.symbol_length,
                         head.symbol_text};
  assign m_axis_tlast = head.formula_end;

endmodule

/* design/cft_parse.sv */
// Tokenizer state and per-character step logic.
// Produces up to two records per character; depends on cft_pkg.
module cft_parse (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cft_pkg::step_t    step_i,
  output cft_pkg::result_t  res_o
);

  logic                            in_symbol_q, in_symbol_d;
  logic                            in_number_q, in_number_d;
  logic [cft_pkg::SymbolBits-1:0]  buffer_q, buffer_d;
  logic [cft_pkg::FillBits-1:0]    fill_q, fill_d;
  logic                            sym_ovf_q, sym_ovf_d;
  logic [cft_pkg::CountBits-1:0]   acc_q, acc_d;
  logic                            cnt_ovf_q, cnt_ovf_d;

  logic                            is_digit, is_upper, is_lower;
  logic [cft_pkg::ProdBits-1:0]    prod;
  logic                            mid_valid;
  cft_pkg::record_t                mid_rec, fin_rec;
  logic [7:0]                      c;

  assign c        = step_i.char_code;
  assign is_digit = c inside {[cft_pkg::CharZero:cft_pkg::CharNine]};
  assign is_upper = c inside {[cft_pkg::CharUpperA:cft_pkg::CharUpperZ]};
  assign is_lower = c inside {[cft_pkg::CharLowerA:cft_pkg::CharLowerZ]};
  assign prod     = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
                  + cft_pkg::ProdBits'(c[3:0]);

  always_comb begin
    in_symbol_d = in_symbol_q;
    in_number_d = in_number_q;
    buffer_d    = buffer_q;
    fill_d      = fill_q;
    sym_ovf_d   = sym_ovf_q;
    acc_d       = acc_q;
    cnt_ovf_d   = cnt_ovf_q;
    mid_valid   = 1'b0;
    mid_rec     = '0;
    fin_rec     = '0;

    if (is_digit) begin
      in_symbol_d = 1'b0;
      if (!in_number_q) begin
        in_number_d = 1'b1;
        acc_d       = cft_pkg::CountBits'(c[3:0]);
        cnt_ovf_d   = 1'b0;
      end else if (prod > cft_pkg::ProdBits'(cft_pkg::CountMax)) begin
        acc_d     = cft_pkg::CountMax;
        cnt_ovf_d = 1'b1;
      end else begin
        acc_d = prod[cft_pkg::CountBits-1:0];
      end
    end else if (is_upper || is_lower) begin
      if (in_number_q) begin
        mid_valid   = 1'b1;
        mid_rec     = '{buffer_q, fill_q, sym_ovf_q, acc_q, cnt_ovf_q, 1'b0};
        in_number_d = 1'b0;
        acc_d       = '0;
        cnt_ovf_d   = 1'b0;
      end
      if (in_symbol_q && is_lower) begin
        if (fill_q < cft_pkg::FillBits'(cft_pkg::SymbolChars)) begin
          for (int i = 0; i < cft_pkg::SymbolChars; i++) begin
            if (fill_q == cft_pkg::FillBits'(i)) begin
              buffer_d[8*i +: 8] = c;
            end
          end
          fill_d = fill_q + cft_pkg::FillBits'(1);
        end else begin
          sym_ovf_d = 1'b1;
        end
      end else begin
        if (in_symbol_q && !in_number_q) begin
          mid_valid = 1'b1;
          mid_rec   = '{buffer_q, fill_q, sym_ovf_q, cft_pkg::CountOne, 1'b0, 1'b0};
        end
        buffer_d    = cft_pkg::SymbolBits'(c);
        fill_d      = cft_pkg::FillBits'(1);
        sym_ovf_d   = 1'b0;
        in_symbol_d = 1'b1;
      end
    end

    if (fill_d != '0) begin
      if (in_number_d) begin
        fin_rec = '{buffer_d, fill_d, sym_ovf_d, acc_d, cnt_ovf_d, 1'b1};
      end else begin
        fin_rec = '{buffer_d, fill_d, sym_ovf_d, cft_pkg::CountOne, 1'b0, 1'b1};
      end
    end else begin
      fin_rec             = '0;
      fin_rec.formula_end = 1'b1;
    end

    if (step_i.last_char) begin
      in_symbol_d = 1'b0;
      in_number_d = 1'b0;
      buffer_d    = '0;
      fill_d      = '0;
      sym_ovf_d   = 1'b0;
      acc_d       = '0;
      cnt_ovf_d   = 1'b0;
    end
  end

  always_comb begin
    res_o.rec0 = mid_valid ? mid_rec : fin_rec;
    res_o.rec1 = fin_rec;
    res_o.num  = '0;
    if (step_i.valid) begin
      res_o.num = {1'b0, mid_valid} + {1'b0, step_i.last_char};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_symbol_q <= 1'b0;
      in_number_q <= 1'b0;
      buffer_q    <= '0;
      fill_q      <= '0;
      sym_ovf_q   <= 1'b0;
      acc_q       <= '0;
      cnt_ovf_q   <= 1'b0;
    end else if (step_i.valid) begin
      in_symbol_q <= in_symbol_d;
      in_number_q <= in_number_d;
      buffer_q    <= buffer_d;
      fill_q      <= fill_d;
      sym_ovf_q   <= sym_ovf_d;
      acc_q       <= acc_d;
      cnt_ovf_q   <= cnt_ovf_d;
    end
  end

endmodule

/* design/cft_fifo.sv */
// Result queue: takes up to two records per cycle, hands out one per word.
// Depends on cft_pkg.
module cft_fifo (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cft_pkg::result_t             res_i,
  input  logic                         pop_i,
  output cft_pkg::record_t             head_o,
  output logic                         nonempty_o,
  output logic [cft_pkg::LvlBits-1:0]  level_o
);

  cft_pkg::record_t              mem_q [cft_pkg::FifoDepth];
  logic [cft_pkg::PtrBits-1:0]   wr_ptr_q, rd_ptr_q;
  logic [cft_pkg::LvlBits-1:0]   level_q, level_d;
  logic [cft_pkg::PtrBits-1:0]   wr_next;

  assign wr_next    = wr_ptr_q + cft_pkg::PtrBits'(1);
  assign head_o     = mem_q[rd_ptr_q];
  assign nonempty_o = (level_q != '0);
  assign level_o    = level_q;
  assign level_d    = level_q + cft_pkg::LvlBits'(res_i.num)
                    - cft_pkg::LvlBits'(pop_i);

  always_ff @(posedge clk_i) begin
    if (res_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= res_i.rec0;
    end
    if (res_i.num == 2'd2) begin
      mem_q[wr_next] <= res_i.rec1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + cft_pkg::PtrBits'(res_i.num);
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + cft_pkg::PtrBits'(1);
      end
      level_q <= level_d;
    end
  end

endmodule

/* design/cft_checker.sv */
// Port-level checks on the tokenizer output stream, bound to the top level.
// Depends on chemical_formula_tokenizer_core and cft_pkg.
module cft_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [cft_pkg::TdataBits-1:0]  m_axis_tdata,
  input logic                           m_axis_tlast
);

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output word changed");

  a_empty_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[25:24] == 2'd0) |-> (m_axis_tdata[23:0] == 24'd0))
    else $error("empty symbol carries text");

  a_sat_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[43] |-> (m_axis_tdata[42:27] == cft_pkg::CountMax))
    else $error("saturated count below maximum");

  a_trunc_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[26] |->
      (m_axis_tdata[25:24] == cft_pkg::FillBits'(cft_pkg::SymbolChars)))
    else $error("truncated symbol not full");

endmodule

bind chemical_formula_tokenizer_core cft_checker u_cft_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
